// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the normalizer checkers. The macros expect clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RMMN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rmmn check failed");

// Next-cycle implication.
`define RMMN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rmmn check failed");

`endif

// ===== sv/rmmn_pkg.sv =====
// ----------------------------------------------------------------------------
// rmmn_pkg
// Shared widths, codes and the front-to-back queue entry of the normalizer.
// ----------------------------------------------------------------------------
package rmmn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 14;
  localparam int NORM_BITS   = FRAC_BITS + 2;
  localparam int EPS_BITS    = 10;
  localparam int CH_BITS     = 4;
  localparam int DEN_BITS    = SAMPLE_BITS + EPS_BITS;
  // numerator is pre-scaled by 2^(FRAC_BITS+EPS_BITS); the first NORM_BITS
  // quotient bits come from the divider, the rest is this fixed shift
  localparam int PRESHIFT    = FRAC_BITS + EPS_BITS - NORM_BITS;

  localparam int IN_DATA_BITS  = ((CH_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((NORM_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8;

  localparam int QDEPTH = 2;

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(1);

  localparam logic OP_LEARN = 1'b0;
  localparam logic OP_NORM  = 1'b1;

  localparam logic [NORM_BITS-1:0] NORM_MAX = {1'b0, {(NORM_BITS-1){1'b1}}};
  localparam logic [NORM_BITS-1:0] NORM_MIN = {1'b1, {(NORM_BITS-1){1'b0}}};
  localparam logic [NORM_BITS:0]   NEG_LIMIT = (NORM_BITS+1)'(1) << (NORM_BITS-1);

  // one classified request on its way to the divider side
  typedef struct packed {
    logic                          need_div;
    logic signed [SAMPLE_BITS:0]   diff;   // sample minus lower bound
    logic [DEN_BITS-1:0]           den;    // (span << 10) + eps
    logic signed [SAMPLE_BITS-1:0] low;
    logic signed [SAMPLE_BITS-1:0] high;
  } qent_t;

endpackage

// ===== sv/rmmn_front.sv =====
// ----------------------------------------------------------------------------
// rmmn_front
// Accepts requests, keeps per-channel bounds and builds divider operands.
// ----------------------------------------------------------------------------
module rmmn_front #(
  parameter int CHANNELS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rmmn_pkg::IN_DATA_BITS-1:0] in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_wr_en,
  input  logic [rmmn_pkg::EPS_BITS-1:0]     cfg_wr_data,
  input  logic                              q_full,
  output logic                              q_push,
  output rmmn_pkg::qent_t                   q_data
);

  localparam int SB       = rmmn_pkg::SAMPLE_BITS;
  localparam int IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CALC = 1'b1;

  logic                          f_state_r;
  logic                          op_r;
  logic                          in_range_r;
  logic [IDX_BITS-1:0]           idx_r;
  logic signed [SB-1:0]          sample_r;
  logic signed [SB-1:0]          lo_rd_r;
  logic signed [SB-1:0]          hi_rd_r;
  logic                          fp_rd_r;
  logic [rmmn_pkg::EPS_BITS-1:0] eps_r;
  logic signed [SB-1:0]          lo_mem_r [CHANNELS];
  logic signed [SB-1:0]          hi_mem_r [CHANNELS];
  logic [CHANNELS-1:0]           fp_r;

  logic [rmmn_pkg::CH_BITS-1:0]          ch_in;
  logic [IDX_BITS+rmmn_pkg::CH_BITS-1:0] ch_ext;
  logic [IDX_BITS-1:0]                   idx_in;
  logic                                  range_in;
  logic                                  accept;
  logic signed [SB-1:0]                  low_cur;
  logic signed [SB-1:0]                  high_cur;
  logic signed [SB-1:0]                  low_new;
  logic signed [SB-1:0]                  high_new;
  logic signed [SB:0]                    span;
  logic [SB-1:0]                         span_u;
  logic [rmmn_pkg::EPS_BITS-1:0]         eps_eff;
  logic                                  is_learn;
  logic                                  wr_en;

  assign ch_in    = in_tdata[rmmn_pkg::CH_BITS-1:0];
  assign ch_ext   = (IDX_BITS+rmmn_pkg::CH_BITS)'(ch_in);
  assign idx_in   = ch_ext[IDX_BITS-1:0];
  assign range_in = (32'(ch_in) < 32'(CHANNELS));

  assign in_tready = (f_state_r == F_IDLE);
  assign accept    = in_tvalid && in_tready;

  // a channel never learned reads as zero bounds
  assign low_cur  = fp_rd_r ? '0 : lo_rd_r;
  assign high_cur = fp_rd_r ? '0 : hi_rd_r;

  always_comb begin
    if (fp_rd_r) begin
      low_new  = sample_r;
      high_new = sample_r;
    end else begin
      low_new  = (sample_r < low_cur)  ? sample_r : low_cur;
      high_new = (sample_r > high_cur) ? sample_r : high_cur;
    end
  end

  assign span    = {high_cur[SB-1], high_cur} - {low_cur[SB-1], low_cur};
  assign span_u  = span[SB] ? '0 : span[SB-1:0];
  assign eps_eff = (eps_r == '0) ? rmmn_pkg::EPS_RESET : eps_r;

  assign is_learn = in_range_r && (op_r == rmmn_pkg::OP_LEARN);
  assign q_push   = (f_state_r == F_CALC) && !q_full;
  assign wr_en    = q_push && is_learn;

  always_comb begin
    q_data.need_div = in_range_r && (op_r == rmmn_pkg::OP_NORM);
    q_data.diff     = {sample_r[SB-1], sample_r} - {low_cur[SB-1], low_cur};
    q_data.den      = {span_u, eps_eff};
    if (!in_range_r) begin
      q_data.low  = '0;
      q_data.high = '0;
    end else if (is_learn) begin
      q_data.low  = low_new;
      q_data.high = high_new;
    end else begin
      q_data.low  = low_cur;
      q_data.high = high_cur;
    end
  end

  // bound memory: registered read at accept, write when the request leaves
  always_ff @(posedge clk) begin
    if (accept && range_in) begin
      lo_rd_r <= lo_mem_r[idx_in];
      hi_rd_r <= hi_mem_r[idx_in];
    end
    if (wr_en) begin
      lo_mem_r[idx_r] <= low_new;
      hi_mem_r[idx_r] <= high_new;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_tuser;
      in_range_r <= range_in;
      idx_r      <= idx_in;
      sample_r   <= in_tdata[rmmn_pkg::CH_BITS +: SB];
      fp_rd_r    <= range_in ? fp_r[idx_in] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_state_r <= F_IDLE;
      fp_r      <= '1;
      eps_r     <= rmmn_pkg::EPS_RESET;
    end else begin
      if (cfg_wr_en) begin
        eps_r <= cfg_wr_data;
      end
      if (wr_en) begin
        fp_r[idx_r] <= 1'b0;
      end
      unique case (f_state_r)
        F_IDLE: if (accept) f_state_r <= F_CALC;
        F_CALC: if (!q_full) f_state_r <= F_IDLE;
        default: f_state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rmmn_fifo.sv =====
// ----------------------------------------------------------------------------
// rmmn_fifo
// Short request queue between the front and the divider side.
// ----------------------------------------------------------------------------
module rmmn_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rmmn_pkg::qent_t push_data,
  output logic            full,
  input  logic            pop,
  output rmmn_pkg::qent_t pop_data,
  output logic            empty
);

  localparam int PTR_BITS = (rmmn_pkg::QDEPTH > 1) ? $clog2(rmmn_pkg::QDEPTH) : 1;
  localparam int CNT_BITS = $clog2(rmmn_pkg::QDEPTH + 1);

  rmmn_pkg::qent_t     ent_r [rmmn_pkg::QDEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (count_r == CNT_BITS'(rmmn_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = ent_r[rd_ptr_r];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(rmmn_pkg::QDEPTH - 1)) ? '0 : p + PTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/rmmn_back.sv =====
// ----------------------------------------------------------------------------
// rmmn_back
// Bit-serial restoring divider, rounding/saturation and the output register.
// ----------------------------------------------------------------------------
module rmmn_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_empty,
  input  rmmn_pkg::qent_t                    q_data,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rmmn_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                               out_tuser
);

  localparam int SB  = rmmn_pkg::SAMPLE_BITS;
  localparam int NB  = rmmn_pkg::NORM_BITS;
  localparam int DB  = rmmn_pkg::DEN_BITS;
  localparam int CNT_BITS = $clog2(NB);

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_DIV  = 2'd1;
  localparam logic [1:0] B_FIN  = 2'd2;

  logic [1:0]           b_state_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 neg_r;
  logic                 big_r;
  logic [DB-1:0]        rem_r;
  logic [DB-1:0]        den_r;
  logic [NB-1:0]        quo_r;
  logic [SB-1:0]        low_r;
  logic [SB-1:0]        high_r;
  logic                 out_valid_r;
  logic [NB-1:0]        out_norm_r;
  logic                 out_sat_r;
  logic [SB-1:0]        out_low_r;
  logic [SB-1:0]        out_high_r;

  logic                 slot_free;
  logic                 load_div;
  logic                 pass_thru;
  logic                 write_out;
  logic                 q_neg;
  logic [SB:0]          q_negd;
  logic [SB-1:0]        q_mag;
  logic [DB-1:0]        q_rem0;
  logic [DB+1:0]        trial;
  logic                 ge;
  logic [NB:0]          qq;
  logic                 fin_sat;
  logic [NB-1:0]        fin_val;
  logic [NB-1:0]        res_norm;
  logic                 res_sat;
  logic [SB-1:0]        res_low;
  logic [SB-1:0]        res_high;

  assign slot_free = !out_valid_r || out_tready;

  // operand setup: magnitude of the numerator and early overflow test
  assign q_neg  = q_data.diff[SB];
  assign q_negd = -q_data.diff;
  assign q_mag  = q_neg ? q_negd[SB-1:0] : q_data.diff[SB-1:0];
  assign q_rem0 = DB'({q_mag, {rmmn_pkg::PRESHIFT{1'b0}}});

  assign pass_thru = (b_state_r == B_IDLE) && !q_empty && !q_data.need_div && slot_free;
  assign load_div  = (b_state_r == B_IDLE) && !q_empty && q_data.need_div;
  assign q_pop     = pass_thru || load_div;

  // one quotient bit per cycle
  assign trial = {1'b0, rem_r, 1'b0} - {2'b00, den_r};
  assign ge    = !trial[DB+1];

  // floor rounding for negative quotients, then clip to NB signed bits
  assign qq = {1'b0, quo_r} + (NB+1)'(|rem_r);
  always_comb begin
    if (!neg_r) begin
      fin_sat = big_r || quo_r[NB-1];
      fin_val = fin_sat ? rmmn_pkg::NORM_MAX : quo_r;
    end else begin
      fin_sat = big_r || (qq > rmmn_pkg::NEG_LIMIT);
      fin_val = fin_sat ? rmmn_pkg::NORM_MIN : NB'(-qq);
    end
  end

  assign write_out = pass_thru || ((b_state_r == B_FIN) && slot_free);

  always_comb begin
    if (b_state_r == B_FIN) begin
      res_norm = fin_val;
      res_sat  = fin_sat;
      res_low  = low_r;
      res_high = high_r;
    end else begin
      res_norm = '0;
      res_sat  = 1'b0;
      res_low  = q_data.low;
      res_high = q_data.high;
    end
  end

  always_ff @(posedge clk) begin
    if (load_div) begin
      neg_r  <= q_neg;
      big_r  <= (q_rem0 >= q_data.den);
      rem_r  <= q_rem0;
      den_r  <= q_data.den;
      quo_r  <= '0;
      low_r  <= q_data.low;
      high_r <= q_data.high;
    end else if (b_state_r == B_DIV) begin
      rem_r <= ge ? trial[DB-1:0] : {rem_r[DB-2:0], 1'b0};
      quo_r <= {quo_r[NB-2:0], ge};
    end
    if (write_out) begin
      out_norm_r <= res_norm;
      out_sat_r  <= res_sat;
      out_low_r  <= res_low;
      out_high_r <= res_high;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_state_r   <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (write_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (b_state_r)
        B_IDLE: begin
          if (load_div) begin
            cnt_r     <= '0;
            b_state_r <= (q_rem0 >= q_data.den) ? B_FIN : B_DIV;
          end
        end
        B_DIV: begin
          cnt_r <= cnt_r + CNT_BITS'(1);
          if (cnt_r == CNT_BITS'(NB - 1)) b_state_r <= B_FIN;
        end
        B_FIN: begin
          if (slot_free) b_state_r <= B_IDLE;
        end
        default: b_state_r <= B_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sat_r;
  assign out_tdata  = rmmn_pkg::OUT_DATA_BITS'({out_high_r, out_low_r, out_norm_r});

endmodule

// ===== sv/running_min_max_normalizer_core.sv =====
// ----------------------------------------------------------------------------
// running_min_max_normalizer_core
// Per-channel running min/max tracker with Q2.14 normalization.
// ----------------------------------------------------------------------------
// Each request is a learn or a normalize operation on one channel. Learn
// widens the channel bounds (the first sample sets both); normalize returns
// floor((x-min)*2^24 / (((max-min)<<10)+eps)) in Q2.14, clipped to 16 bits
// with a saturation flag. Every request yields exactly one response carrying
// the channel bounds after the request; a channel index at or beyond CHANNELS
// changes nothing and returns all zeros. The front reads the bound memory
// when it takes a request, then updates and queues it, and takes no new
// request until that one is queued. A normalize request occupies the
// bit-serial restoring divider through a load step, one iteration per
// quotient bit and a finish step; the divider takes no new request until
// it has finished with the current one, and an obvious overflow skips the
// iterations. A two-entry queue between front and divider and the output
// register let either side stall independently. Bounds need no clearing pass
// after reset: per-channel first-sample flags mask memory contents that were
// never written. epsilon should only be written while the block is idle; zero
// acts as one.
// ----------------------------------------------------------------------------
module running_min_max_normalizer_core #(
  parameter int CHANNELS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request side
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rmmn_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [3:0] channel, [19:4] sample
  input  logic                               in_tuser,   // [0] opcode
  // response side
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rmmn_pkg::OUT_DATA_BITS-1:0] out_tdata,  // [15:0] normalized,
                                                         // [31:16] bound_low,
                                                         // [47:32] bound_high
  output logic                               out_tuser,  // [0] saturated
  // epsilon register
  input  logic                               cfg_wr_en,
  input  logic [rmmn_pkg::EPS_BITS-1:0]      cfg_wr_data
);

  rmmn_pkg::qent_t push_data;
  rmmn_pkg::qent_t pop_data;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  // front: bound state, classification, operand build
  rmmn_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  // decoupling queue
  rmmn_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // back: divider and response register
  rmmn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== sv/rmmn_checker.sv =====
// ----------------------------------------------------------------------------
// rmmn_checker
// Port-level checks for the normalizer core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmmn_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [rmmn_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input logic                               out_tuser
);

  localparam int SB = rmmn_pkg::SAMPLE_BITS;
  localparam int NB = rmmn_pkg::NORM_BITS;

  logic signed [SB-1:0] bnd_lo;
  logic signed [SB-1:0] bnd_hi;
  logic [NB-1:0]        norm;

  assign norm   = out_tdata[NB-1:0];
  assign bnd_lo = out_tdata[NB +: SB];
  assign bnd_hi = out_tdata[NB+SB +: SB];

  // stalled response holds
  `RMMN_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // bounds never cross
  `RMMN_ASSERT_NOW(a_bounds_order, out_tvalid, bnd_hi >= bnd_lo)

  // saturation only ever shows a rail value
  `RMMN_ASSERT_NOW(a_sat_rail, out_tvalid && out_tuser,
    (norm == rmmn_pkg::NORM_MAX) || (norm == rmmn_pkg::NORM_MIN))

  // front drops ready after each accepted request
  `RMMN_ASSERT_NEXT(a_front_gap, in_tvalid && in_tready, !in_tready)

endmodule

bind running_min_max_normalizer_core rmmn_checker u_rmmn_checker (.*);

// ===== bench/tb_running_min_max_normalizer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_running_min_max_normalizer_core
// Self-checking bench for the running min/max normalizer. A short table of
// directed requests covers corner samples, bad channels and first-sample
// behavior. Randomized passes follow, each under its own epsilon value and one of
// three backpressure mixes. Each response is checked field by field against a
// typed table response or a model of channel bounds and floored Q2.14 division.
// ----------------------------------------------------------------------------
module tb_running_min_max_normalizer_core;

  localparam int SAMPLE_BITS   = rmmn_pkg::SAMPLE_BITS;
  localparam int FRAC_BITS     = rmmn_pkg::FRAC_BITS;
  localparam int NORM_BITS     = rmmn_pkg::NORM_BITS;
  localparam int EPS_BITS      = rmmn_pkg::EPS_BITS;
  localparam int CH_BITS       = rmmn_pkg::CH_BITS;
  localparam int IN_DATA_BITS  = rmmn_pkg::IN_DATA_BITS;
  localparam int OUT_DATA_BITS = rmmn_pkg::OUT_DATA_BITS;
  localparam logic OP_LEARN    = rmmn_pkg::OP_LEARN;
  localparam logic OP_NORM     = rmmn_pkg::OP_NORM;
  localparam logic [NORM_BITS-1:0] NORM_MAX  = rmmn_pkg::NORM_MAX;
  localparam logic [NORM_BITS-1:0] NORM_MIN  = rmmn_pkg::NORM_MIN;
  localparam logic [EPS_BITS-1:0]  EPS_RESET = rmmn_pkg::EPS_RESET;

  localparam int NUM_CH         = 12;
  localparam int CLK_HALF       = 4;     // 8 ns period
  localparam int RESET_CYCLES   = 10;
  localparam int NUM_PASSES     = 6;
  localparam int ITEMS_PER_PASS = 240;
  localparam int HOLD_CYCLES    = 300;   // long output stall, fills the pipe
  localparam int SETTLE_CYCLES  = 32;    // settle time after the last response
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
  localparam int QUO_SHIFT      = FRAC_BITS + EPS_BITS;
  localparam longint NORM_HI    = (longint'(1) <<< (NORM_BITS - 1)) - 1;
  localparam longint NORM_LO    = -NORM_HI - 1;

  // one response: its data fields and the saturation flag
  typedef struct packed {
    logic signed [NORM_BITS-1:0]   normalized;
    logic                          saturated;
    logic signed [SAMPLE_BITS-1:0] bound_low;
    logic signed [SAMPLE_BITS-1:0] bound_high;
  } norm_result_t;

  // one request plus an optional hand-typed response
  typedef struct packed {
    logic                          op;
    logic [CH_BITS-1:0]            ch;
    logic signed [SAMPLE_BITS-1:0] smp;
    bit                            pinned;
    norm_result_t                  res;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;    // [3:0] channel, [19:4] sample
  logic                     in_tuser;    // [0] opcode
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;   // [15:0] normalized, [31:16] bound_low,
                                         // [47:32] bound_high
  logic                     out_tuser;   // [0] saturated
  logic                     cfg_wr_en;
  logic [EPS_BITS-1:0]      cfg_wr_data;

  // side band that travels with the request on offer
  bit                       req_pinned;
  norm_result_t             req_pinned_res;

  // model copy of the block state
  logic signed [SAMPLE_BITS-1:0] lo_bound [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] hi_bound [NUM_CH];
  bit                            unseen   [NUM_CH];
  logic [EPS_BITS-1:0]           eps_model;

  norm_result_t expected_q[$];
  stim_row_t    directed_rows[$];

  int  src_idle_pct  = 0;
  int  sink_idle_pct = 0;
  bit  sink_hold_req = 1'b0;
  int  idle_cycles   = 0;
  int  n_learn = 0, n_norm = 0, n_clip = 0, n_badch = 0;
  int  n_checked = 0, n_errors = 0;

  running_min_max_normalizer_core #(
    .CHANNELS(NUM_CH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model: update bounds on learn, floored scaled divide on normalize.
  // Bad channels touch nothing and answer all zeros.
  // --------------------------------------------------------------------------
  function automatic norm_result_t predict_request(input logic op,
                                                   input logic [CH_BITS-1:0] ch,
                                                   input logic signed [SAMPLE_BITS-1:0] smp);
    norm_result_t r;
    longint       span, numer, denom, quo;
    r = '0;
    if (ch >= NUM_CH) return r;
    if (op == OP_LEARN) begin
      if (unseen[ch]) begin
        lo_bound[ch] = smp;
        hi_bound[ch] = smp;
        unseen[ch]   = 1'b0;
      end else begin
        if (smp < lo_bound[ch]) lo_bound[ch] = smp;
        if (smp > hi_bound[ch]) hi_bound[ch] = smp;
      end
    end else begin
      span = longint'(hi_bound[ch]) - longint'(lo_bound[ch]);
      if (span < 0) span = 0;
      // a zero epsilon behaves as one so the divisor never vanishes
      denom = (span <<< EPS_BITS) + ((eps_model == '0) ? 1 : longint'(eps_model));
      numer = (longint'(smp) - longint'(lo_bound[ch])) <<< QUO_SHIFT;
      quo   = numer / denom;
      // SV division truncates; pull negative quotients down to the floor
      if (numer < 0 && (numer % denom) != 0) quo = quo - 1;
      if (quo > NORM_HI) begin
        r.normalized = NORM_MAX;
        r.saturated  = 1'b1;
      end else if (quo < NORM_LO) begin
        r.normalized = NORM_MIN;
        r.saturated  = 1'b1;
      end else begin
        r.normalized = quo[NORM_BITS-1:0];
      end
    end
    r.bound_low  = lo_bound[ch];
    r.bound_high = hi_bound[ch];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: predict at the accepting edge and queue the expectation.
  // Table rows with a typed response queue that one instead; the model
  // still runs so its state stays in step.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : request_monitor
    norm_result_t predicted;
    if (rst_n && in_tvalid && in_tready) begin
      predicted = predict_request(in_tuser, in_tdata[CH_BITS-1:0],
                                  in_tdata[CH_BITS +: SAMPLE_BITS]);
      expected_q.push_back(req_pinned ? req_pinned_res : predicted);
      if (in_tdata[CH_BITS-1:0] >= NUM_CH) begin
        n_badch++;
      end else if (in_tuser == OP_LEARN) begin
        n_learn++;
      end else begin
        n_norm++;
        if (predicted.saturated) n_clip++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: compare each accepted response with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    norm_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got.normalized = out_tdata[NORM_BITS-1:0];
      got.bound_low  = out_tdata[NORM_BITS +: SAMPLE_BITS];
      got.bound_high = out_tdata[NORM_BITS + SAMPLE_BITS +: SAMPLE_BITS];
      got.saturated  = out_tuser;
      if (expected_q.size() == 0) begin
        $error("response with no request pending: normalized %0d, bounds %0d..%0d",
               got.normalized, got.bound_low, got.bound_high);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        if (got.normalized !== want.normalized) begin
          $error("normalized mismatch: expected %0d, got %0d", want.normalized,
                 got.normalized);
          n_errors++;
        end
        if (got.saturated !== want.saturated) begin
          $error("saturated mismatch: expected %0d, got %0d", want.saturated,
                 got.saturated);
          n_errors++;
        end
        if (got.bound_low !== want.bound_low) begin
          $error("bound_low mismatch: expected %0d, got %0d", want.bound_low,
                 got.bound_low);
          n_errors++;
        end
        if (got.bound_high !== want.bound_high) begin
          $error("bound_high mismatch: expected %0d, got %0d", want.bound_high,
                 got.bound_high);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles, %0d responses outstanding", idle_cycles,
             expected_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Output ready: random idling, or a long hold when asked. The hold is
  // counted here so the request side keeps offering until the block backs up.
  // --------------------------------------------------------------------------
  initial begin : sink_driver
    int held;
    out_tready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_tready <= (int'($urandom_range(0, 99)) >= sink_idle_pct);
      end
    end
  end

  task automatic add_row(input logic op, input int ch, input int smp,
                         input bit pin = 1'b0, input int e_norm = 0,
                         input bit e_sat = 1'b0, input int e_lo = 0, input int e_hi = 0);
    stim_row_t row;
    row.op             = op;
    row.ch             = ch[CH_BITS-1:0];
    row.smp            = smp[SAMPLE_BITS-1:0];
    row.pinned         = pin;
    row.res.normalized = e_norm[NORM_BITS-1:0];
    row.res.saturated  = e_sat;
    row.res.bound_low  = e_lo[SAMPLE_BITS-1:0];
    row.res.bound_high = e_hi[SAMPLE_BITS-1:0];
    directed_rows.push_back(row);
  endtask

  // Offer one request, with random gaps ahead of it, and hold it until taken.
  task automatic send_request(input stim_row_t row);
    while (int'($urandom_range(0, 99)) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid      <= 1'b1;
    in_tuser       <= row.op;
    in_tdata       <= IN_DATA_BITS'({row.smp, row.ch});
    req_pinned     <= row.pinned;
    req_pinned_res <= row.res;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid, wait for every response, then let the divider settle.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_epsilon(input logic [EPS_BITS-1:0] val);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eps_model = val;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random request: mostly good channels. Learn samples cluster around a
  // per-channel center so spans stay moderate; only the upper channels see
  // wild learns. Normalize samples aim around the learned range, with
  // corners and raw noise mixed in.
  // --------------------------------------------------------------------------
  task automatic draw_request(output stim_row_t row);
    int ch, lo, hi, margin, v;
    row = '0;
    if ($urandom_range(0, 99) < 8) ch = $urandom_range(NUM_CH, 15);
    else ch = $urandom_range(0, NUM_CH - 1);
    row.ch = ch[CH_BITS-1:0];
    row.op = ($urandom_range(0, 99) < 40) ? OP_LEARN : OP_NORM;
    if (ch >= NUM_CH) begin
      v = $urandom;
    end else if (row.op == OP_LEARN) begin
      if (ch >= 8 && $urandom_range(0, 99) < 20) v = $urandom;
      else v = (ch - 6) * 4000 + int'($urandom_range(0, 1200)) - 600;
    end else begin
      lo = lo_bound[ch];
      hi = hi_bound[ch];
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(0, 3))
            0:       v = -32768;
            1:       v = 32767;
            2:       v = 0;
            default: v = -1;
          endcase
        end
        2, 3, 4: v = $urandom;
        default: begin
          margin = (hi - lo) / 2 + 4;
          v = lo - margin + int'($urandom_range(0, hi - lo + 2 * margin));
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
        end
      endcase
    end
    row.smp = v[SAMPLE_BITS-1:0];
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t           row;
    logic [EPS_BITS-1:0] pass_eps [NUM_PASSES];
    int                  pass, k;

    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = OP_LEARN;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    req_pinned     = 1'b0;
    req_pinned_res = '0;
    for (k = 0; k < NUM_CH; k++) begin
      lo_bound[k] = '0;
      hi_bound[k] = '0;
      unseen[k]   = 1'b1;
    end
    eps_model = EPS_RESET;

    // Directed table, epsilon at its reset value of one. Rows with typed
    // responses are the ones readable by eye.
    // fresh channel: bounds 0..0, zero sample gives zero
    add_row(OP_NORM,  0,      0, 1,      0, 0,      0,      0);
    // fresh channel, any nonzero offset over a divisor of one clips
    add_row(OP_NORM,  1,  32767, 1,  32767, 1,      0,      0);
    add_row(OP_NORM,  1, -32768, 1, -32768, 1,      0,      0);
    // bad channels answer all zeros and leave state alone
    add_row(OP_NORM,  15,  1234, 1);
    add_row(OP_LEARN, 12,    -1, 1);
    add_row(OP_NORM,  13, -32768, 1);
    add_row(OP_LEARN, 14, 32767, 1);
    // first learn sets both bounds, then the full sample range
    add_row(OP_LEARN, 2, -32768, 1,      0, 0, -32768, -32768);
    add_row(OP_LEARN, 2,  32767, 1,      0, 0, -32768,  32767);
    add_row(OP_NORM,  2, -32768, 1,      0, 0, -32768,  32767);
    add_row(OP_NORM,  2,  32767);
    add_row(OP_NORM,  2,      0);
    // later learns only widen
    add_row(OP_LEARN, 3,    100, 1,      0, 0,    100,    100);
    add_row(OP_LEARN, 3,     50, 1,      0, 0,     50,    100);
    add_row(OP_LEARN, 3,     75, 1,      0, 0,     50,    100);
    // mid range, above range, below range, far below (negative clip)
    add_row(OP_NORM,  3,     75);
    add_row(OP_NORM,  3,    200);
    add_row(OP_NORM,  3,      0);
    add_row(OP_NORM,  3,   -100);
    // zero span: only epsilon in the divisor
    add_row(OP_LEARN, 11,    -1, 1,      0, 0,     -1,     -1);
    add_row(OP_NORM,  11,    -1, 1,      0, 0,     -1,     -1);
    add_row(OP_NORM,  11,     0, 1,  32767, 1,     -1,     -1);
    // alternating sample bit patterns
    add_row(OP_LEARN, 4,  21845);
    add_row(OP_LEARN, 9, -21846);
    add_row(OP_NORM,  5,      0, 1,      0, 0,      0,      0);

    src_idle_pct  = 22;
    sink_idle_pct = 59;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) send_request(directed_rows[k]);

    // epsilon per pass: all ones, zero (acts as one), random, one, top bit,
    // random
    pass_eps[0] = '1;
    pass_eps[1] = '0;
    pass_eps[2] = EPS_BITS'($urandom_range(2, 1022));
    pass_eps[3] = EPS_RESET;
    pass_eps[4] = EPS_BITS'(1 << (EPS_BITS - 1));
    pass_eps[5] = EPS_BITS'($urandom_range(2, 1022));

    for (pass = 0; pass < NUM_PASSES; pass++) begin
      set_epsilon(pass_eps[pass]);
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (pass < 2) begin
        src_idle_pct  = 22;
        sink_idle_pct = 59;
      end else if (pass < 4) begin
        src_idle_pct  = 59;
        sink_idle_pct = 22;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      // long output hold while requests keep coming
      if (pass == 0 || pass == 4) sink_hold_req = 1'b1;
      for (k = 0; k < ITEMS_PER_PASS; k++) begin
        draw_request(row);
        send_request(row);
      end
    end

    wait_for_results();

    $display("Covered %0d learn, %0d normalize (%0d clipped), %0d bad-channel requests;",
             n_learn, n_norm, n_clip, n_badch);
    $display("%0d responses checked across six epsilon values and three stall mixes.",
             n_checked);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
